/* sv/cpg_pkg.sv */
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared types and constants for the cyclic palette gradient.
// ----------------------------------------------------------------------------
package cpg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = FRAC_BITS + 1;
  localparam int CHAN_W    = 8;
  localparam int COLOR_W   = 3 * CHAN_W;
  localparam int NUM_STOPS = 5;
  localparam int SEG_W     = 3;
  localparam int PROD_W    = POS_W + 2;           // position times up to five
  localparam int MULT_W    = CHAN_W + POS_W;      // channel times weight
  localparam int MODE_W    = 2;
  localparam int IDX_W     = 3;

  localparam logic [POS_W-1:0] ONE  = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] HALF = POS_W'(1) << (FRAC_BITS - 1);

  // Register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_STOP_MODE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_STOP_COLOR_0 = 3'd1;
  localparam logic [IDX_W-1:0] REG_STOP_COLOR_4 = 3'd5;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_PING_PONG = 2'd0;
  localparam logic [MODE_W-1:0] MODE_THREE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FOUR      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FIVE      = 2'd3;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [POS_W-1:0] weight_t;
  typedef color_t [NUM_STOPS-1:0] palette_t;

  // Payload handed from the segment stage to the blend stages
  typedef struct packed {
    weight_t weight;
    color_t  color_a;
    color_t  color_b;
  } mix_req_t;

  localparam palette_t RESET_PALETTE = {
    24'h3A86FF, 24'h8338EC, 24'hFF006E, 24'hFB5607, 24'hFABE0B
  };
  localparam logic [MODE_W-1:0] RESET_MODE = MODE_FIVE;

endpackage

/* sv/cpg_cfg.sv */
// ----------------------------------------------------------------------------
// cpg_cfg
// Configuration registers: stop mode and the five palette stops.
// ----------------------------------------------------------------------------
module cpg_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [cpg_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cpg_pkg::COLOR_W-1:0] cfg_data,
  output logic [cpg_pkg::MODE_W-1:0]  stop_mode,
  output cpg_pkg::palette_t           palette
);
  import cpg_pkg::*;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_mode <= RESET_MODE;
      palette   <= RESET_PALETTE;
    end else if (cfg_write) begin
      if (cfg_index == REG_STOP_MODE) begin
        stop_mode <= cfg_data[MODE_W-1:0];
      end else if (cfg_index >= REG_STOP_COLOR_0 && cfg_index <= REG_STOP_COLOR_4) begin
        palette[cfg_index - REG_STOP_COLOR_0] <= cfg_data;
      end
    end
  end

endmodule

/* sv/cpg_seg.sv */
// ----------------------------------------------------------------------------
// cpg_seg
// First stage: saturates the position, finds the segment and blend weight,
// and picks the two stops to blend.
// ----------------------------------------------------------------------------
module cpg_seg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [cpg_pkg::MODE_W-1:0] stop_mode,
  input  cpg_pkg::palette_t          palette,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [cpg_pkg::POS_W-1:0]  position,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output cpg_pkg::mix_req_t          dn_req
);
  import cpg_pkg::*;

  logic [POS_W-1:0]  pos_sat;
  logic [POS_W-1:0]  mid_offset;
  logic [PROD_W-1:0] prod;
  logic [SEG_W-1:0]  n_stops;
  logic [SEG_W-1:0]  seg_raw;
  logic [SEG_W-1:0]  seg;
  logic [SEG_W-1:0]  seg_b;
  mix_req_t          req_next;

  // Saturate above 1.0
  assign pos_sat = (position > ONE) ? ONE : position;

  // Position times stop count, by shift and add
  always_comb begin
    case (stop_mode)
      MODE_THREE: prod = {2'b00, pos_sat} + {1'b0, pos_sat, 1'b0};
      MODE_FOUR:  prod = {pos_sat, 2'b00};
      MODE_FIVE:  prod = {2'b00, pos_sat} + {pos_sat, 2'b00};
      default:    prod = '0;
    endcase
  end

  assign n_stops    = {1'b0, stop_mode} + SEG_W'(2);
  assign seg_raw    = prod[PROD_W-1:FRAC_BITS];
  assign mid_offset = (pos_sat >= HALF) ? (pos_sat - HALF) : (HALF - pos_sat);

  // Segment, weight and stop selection
  always_comb begin
    seg   = seg_raw;
    req_next.weight = {1'b0, prod[FRAC_BITS-1:0]};
    if (seg_raw >= n_stops) begin
      seg             = n_stops - SEG_W'(1);
      req_next.weight = ONE;
    end
    seg_b = (seg == n_stops - SEG_W'(1)) ? '0 : seg + SEG_W'(1);
    req_next.color_a = palette[seg];
    req_next.color_b = palette[seg_b];
    if (stop_mode == MODE_PING_PONG) begin
      req_next.weight  = ONE - {mid_offset[POS_W-2:0], 1'b0};
      req_next.color_a = palette[0];
      req_next.color_b = palette[1];
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_req <= req_next;
    end
  end

endmodule

/* sv/cpg_mix.sv */
// ----------------------------------------------------------------------------
// cpg_mix
// Blend stages: per-channel products, then sum and truncate.
// ----------------------------------------------------------------------------
module cpg_mix (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  cpg_pkg::mix_req_t          up_req,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output logic [cpg_pkg::CHAN_W-1:0] red,
  output logic [cpg_pkg::CHAN_W-1:0] green,
  output logic [cpg_pkg::CHAN_W-1:0] blue
);
  import cpg_pkg::*;

  logic                 prod_valid;
  logic                 prod_ready;
  logic [MULT_W-1:0]    prod_a [3];
  logic [MULT_W-1:0]    prod_b [3];
  logic [MULT_W-1:0]    prod_a_next [3];
  logic [MULT_W-1:0]    prod_b_next [3];
  logic [MULT_W-1:0]    sum [3];
  weight_t              inv_weight;

  assign inv_weight = ONE - up_req.weight;

  // One multiplier pair per channel; channel 0 is red
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_a_next[c] = MULT_W'(up_req.color_a[COLOR_W-1-c*CHAN_W -: CHAN_W]) *
                       MULT_W'(inv_weight);
      prod_b_next[c] = MULT_W'(up_req.color_b[COLOR_W-1-c*CHAN_W -: CHAN_W]) *
                       MULT_W'(up_req.weight);
    end
  end

  assign up_ready   = !prod_valid || prod_ready;
  assign prod_ready = !dn_valid || dn_ready;

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (up_ready) begin
      prod_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      prod_a <= prod_a_next;
      prod_b <= prod_b_next;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = prod_a[c] + prod_b[c];
    end
  end

  // Sum stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (prod_ready) begin
      dn_valid <= prod_valid;
    end
    if (prod_ready && prod_valid) begin
      red   <= sum[0][FRAC_BITS +: CHAN_W];
      green <= sum[1][FRAC_BITS +: CHAN_W];
      blue  <= sum[2][FRAC_BITS +: CHAN_W];
    end
  end

endmodule

/* sv/cyclic_palette_gradient_top.sv */
// ----------------------------------------------------------------------------
// cyclic_palette_gradient_top
// Maps a Q1.16 position to an RGB888 color from a cyclic multi-stop palette.
// ----------------------------------------------------------------------------
// Pipeline: three register stages (segment, product, sum); color valid comes
//   up once the accepted position has passed through all three.
// Throughput: one item per cycle; each stage holds its item under back pressure.
// Reset: synchronous, clears all stage valids and loads the default mode and
//   palette.
module cyclic_palette_gradient_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [cpg_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cpg_pkg::COLOR_W-1:0] cfg_data,
  input  logic                        position_valid,
  output logic                        position_ready,
  input  logic [cpg_pkg::POS_W-1:0]   position,
  output logic                        color_valid,
  input  logic                        color_ready,
  output logic [cpg_pkg::CHAN_W-1:0]  red,
  output logic [cpg_pkg::CHAN_W-1:0]  green,
  output logic [cpg_pkg::CHAN_W-1:0]  blue
);
  import cpg_pkg::*;

  logic [MODE_W-1:0] stop_mode;
  palette_t          palette;
  logic              seg_valid;
  logic              seg_ready;
  mix_req_t          seg_req;

  cpg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stop_mode (stop_mode),
    .palette   (palette)
  );

  cpg_seg u_seg (
    .clk       (clk),
    .rst       (rst),
    .stop_mode (stop_mode),
    .palette   (palette),
    .up_valid  (position_valid),
    .up_ready  (position_ready),
    .position  (position),
    .dn_valid  (seg_valid),
    .dn_ready  (seg_ready),
    .dn_req    (seg_req)
  );

  cpg_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (seg_valid),
    .up_ready (seg_ready),
    .up_req   (seg_req),
    .dn_valid (color_valid),
    .dn_ready (color_ready),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cyclic palette gradient. A scoreboard class
// predicts the blended RGB888 color for every accepted position from its own
// copy of the mode and palette registers. Each color leaving the block is
// compared per channel with the oldest prediction. Directed boundary items
// come first, then randomized positions under a sequence of palette and mode
// settings, with random idling on both sides of the handshake, none in the last third.
// ----------------------------------------------------------------------------
module tb_top;
  import cpg_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 650;
  localparam int BLOCK_ITEMS   = 50;
  localparam int MAX_PRINTED   = 40;

  // Indexes past the last stop register; writes there must be ignored
  localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // --------------------------------------------------------------------------
  // Color predictor and store of expected colors
  // --------------------------------------------------------------------------
  class gradient_scoreboard;
    logic [MODE_W-1:0] mode;
    palette_t          stops;
    rgb_t              color_q[$];
    int                fails;

    function new();
      mode     = MODE_FIVE;
      stops[0] = 24'hFABE0B;
      stops[1] = 24'hFB5607;
      stops[2] = 24'hFF006E;
      stops[3] = 24'h8338EC;
      stops[4] = 24'h3A86FF;
      fails    = 0;
    endfunction

    function void report(string what, int got, int want);
      if (fails < MAX_PRINTED)
        $display("mismatch: %s got %0h want %0h", what, got, want);
      fails++;
    endfunction

    // Mirror of a register write; only the low bits of the mode are kept
    function void load_reg(logic [IDX_W-1:0] idx, color_t data);
      if (idx == REG_STOP_MODE) begin
        mode = data[MODE_W-1:0];
      end else if (idx >= REG_STOP_COLOR_0 && idx <= REG_STOP_COLOR_4) begin
        stops[idx - REG_STOP_COLOR_0] = data;
      end
    endfunction

    function logic [CHAN_W-1:0] mix_chan(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                         int unsigned t);
      int unsigned acc;
      acc = a * (int'(ONE) - t) + b * t;
      return CHAN_W'(acc >> FRAC_BITS);
    endfunction

    function rgb_t blend_color(logic [POS_W-1:0] pos);
      int unsigned posc;
      int unsigned mid_offset;
      int unsigned n;
      int unsigned prod;
      int unsigned seg;
      int unsigned t;
      color_t      ca;
      color_t      cb;
      rgb_t        res;
      posc = (pos > ONE) ? int'(ONE) : int'(pos);
      if (mode == MODE_PING_PONG) begin
        mid_offset = (posc > HALF) ? posc - HALF : HALF - posc;
        t          = ONE - 2 * mid_offset;
        ca         = stops[0];
        cb         = stops[1];
      end else begin
        n    = mode + 2;
        prod = posc * n;
        seg  = prod >> FRAC_BITS;
        t    = prod & (ONE - 1);
        // position one lands in the last segment at full weight
        if (seg >= n) begin
          seg = n - 1;
          t   = ONE;
        end
        ca = stops[seg];
        cb = stops[(seg + 1) % n];
      end
      res.red   = mix_chan(ca[23:16], cb[23:16], t);
      res.green = mix_chan(ca[15:8], cb[15:8], t);
      res.blue  = mix_chan(ca[7:0], cb[7:0], t);
      return res;
    endfunction

    function void note_position(logic [POS_W-1:0] pos);
      color_q.push_back(blend_color(pos));
    endfunction

    function void check_color(rgb_t got);
      rgb_t want;
      if (color_q.size() == 0) begin
        report("color with no position pending", got, 0);
        return;
      end
      want = color_q.pop_front();
      if (got.red !== want.red) report("red", got.red, want.red);
      if (got.green !== want.green) report("green", got.green, want.green);
      if (got.blue !== want.blue) report("blue", got.blue, want.blue);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block instance
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [COLOR_W-1:0]  cfg_data = '0;
  logic                position_valid = 1'b0;
  logic                position_ready;
  logic [POS_W-1:0]    position = '0;
  logic                color_valid;
  logic                color_ready = 1'b0;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;

  int                  send_idle = 22;
  int                  recv_idle = 46;
  int                  cycles = 0;

  gradient_scoreboard  sb = new();

  cyclic_palette_gradient_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .position_valid (position_valid),
    .position_ready (position_ready),
    .position       (position),
    .color_valid    (color_valid),
    .color_ready    (color_ready),
    .red            (red),
    .green          (green),
    .blue           (blue)
  );

  always #1 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Color receiver: check accepted items, stall at random
  always @(posedge clk) begin
    if (!rst && color_valid && color_ready)
      sb.check_color({red, green, blue});
    color_ready <= ($urandom_range(99) >= recv_idle);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One register write per cycle; the caller lowers the write enable
  task automatic write_reg(logic [IDX_W-1:0] idx, color_t data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.load_reg(idx, data);
  endtask

  task automatic send_position(logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle) begin
      position_valid <= 1'b0;
      @(posedge clk);
    end
    position_valid <= 1'b1;
    position       <= pos;
    do @(posedge clk); while (!position_ready);
    sb.note_position(pos);
  endtask

  // Let every pending color come out, then wait out DRAIN_CYCLES
  task automatic drain();
    position_valid <= 1'b0;
    while (sb.color_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Program the mode (random upper bits) and the palette, plus ignored writes
  task automatic program_palette(logic [MODE_W-1:0] mode, int style);
    color_t data;
    write_reg(REG_STOP_MODE, COLOR_W'(($urandom() & 24'hFFFFFC) | mode));
    for (int i = 0; i < NUM_STOPS; i++) begin
      case (style)
        0: data = 24'h000000;
        1: data = 24'hFFFFFF;
        2: data = (i % 2) ? 24'hFFFFFF : 24'h000000;
        default: data = COLOR_W'($urandom());
      endcase
      write_reg(IDX_W'(REG_STOP_COLOR_0 + i), data);
    end
    write_reg(REG_SPARE_6, COLOR_W'($urandom()));
    write_reg(REG_SPARE_7, COLOR_W'($urandom()));
    cfg_write <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] rand_position(logic [MODE_W-1:0] mode);
    int pick;
    int n;
    int k;
    int p;
    pick = $urandom_range(99);
    n    = (mode == MODE_PING_PONG) ? 2 : mode + 2;
    if (pick < 65) begin
      return POS_W'($urandom_range(ONE, 0));
    end else if (pick < 80) begin
      // near a segment edge
      k = $urandom_range(n, 0);
      p = k * int'(ONE) / n + $urandom_range(4, 0) - 2;
      if (p < 0) p = 0;
      return POS_W'(p);
    end else if (pick < 90) begin
      return POS_W'($urandom_range(2 ** POS_W - 1, ONE + 1));
    end else begin
      return POS_W'($urandom());
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [MODE_W-1:0] mode;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset palette, five stops: ends, segment edges, above one
    send_position(0);
    send_position(1);
    send_position(13107);
    send_position(13108);
    send_position(26214);
    send_position(26215);
    send_position(39321);
    send_position(39322);
    send_position(52428);
    send_position(52429);
    send_position(65535);
    send_position(ONE);
    send_position(POS_W'(ONE + 1));
    send_position(POS_W'(2 ** POS_W - 1));
    drain();

    // Ping-pong: ends, center, above one
    write_reg(REG_STOP_MODE, COLOR_W'(MODE_PING_PONG));
    cfg_write <= 1'b0;
    send_position(0);
    send_position(POS_W'(HALF - 1));
    send_position(HALF);
    send_position(POS_W'(HALF + 1));
    send_position(ONE);
    send_position(POS_W'(2 ** POS_W - 1));
    drain();

    // Three stops: segment edges and the wrap to stop zero
    write_reg(REG_STOP_MODE, COLOR_W'(MODE_THREE));
    cfg_write <= 1'b0;
    send_position(21845);
    send_position(21846);
    send_position(43690);
    send_position(43691);
    send_position(ONE);
    drain();

    // Random blocks, each under its own mode and palette
    for (int b = 0; b * BLOCK_ITEMS < RANDOM_ITEMS; b++) begin
      mode = MODE_W'(b % 4);
      program_palette(mode, b % 5);
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        case (((b * BLOCK_ITEMS + i) * 3) / RANDOM_ITEMS)
          0: begin
            send_idle = 22;
            recv_idle = 46;
          end
          1: begin
            send_idle = 46;
            recv_idle = 22;
          end
          default: begin
            send_idle = 0;
            recv_idle = 0;
          end
        endcase
        send_position(rand_position(mode));
      end
      drain();
    end

    if (sb.color_q.size() != 0)
      sb.report("colors never delivered", 0, sb.color_q.size());
    if (sb.fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
